// File: design/fbpa_pkg.sv
// Shared types, widths and codes of the fixed block pool allocator.
`default_nettype none
package fbpa_pkg;

    localparam int unsigned NUM_BLOCKS_DEF = 256;
    localparam int unsigned ALIGN_BYTES    = 8;
    localparam int unsigned ALIGN_SHIFT    = $clog2(ALIGN_BYTES);

    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned ASZ_W    = SIZE_W + 1;
    localparam int unsigned BLOCK_W  = 8;
    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned IN_USE_W = 9;
    localparam int unsigned STATUS_W = 2;

    localparam logic [SIZE_W-1:0] BLK_BYTES_RESET = 16'd64;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LIST_FULL = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } fbpa_shift_t;

endpackage
`default_nettype wire

// File: design/fbpa_cell.sv
// One entry of the free list: takes the neighbour above on a push, below on a pop.
`default_nettype none
module fbpa_cell #(
    parameter int unsigned         ENTRY_W   = 8,
    parameter logic [ENTRY_W-1:0]  RESET_VAL = '0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fbpa_pkg::fbpa_shift_t ctrl,
    input  wire logic [ENTRY_W-1:0]   from_above,
    input  wire logic [ENTRY_W-1:0]   from_below,
    output logic [ENTRY_W-1:0]        value
);
    import fbpa_pkg::*;

    logic [ENTRY_W-1:0] value_reg;
    logic [ENTRY_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        if (ctrl.push) begin
            value_next = from_above;
        end else if (ctrl.pop) begin
            value_next = from_below;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= RESET_VAL;
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// File: design/fbpa_stack.sv
// Free list held as a chain of cells; cell 0 is the top of the stack.
`default_nettype none
module fbpa_stack #(
    parameter int unsigned NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned ENTRY_W    = fbpa_pkg::BLOCK_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fbpa_pkg::fbpa_shift_t ctrl,
    input  wire logic [ENTRY_W-1:0]   push_data,
    output logic [ENTRY_W-1:0]        top_data
);
    import fbpa_pkg::*;

    logic [ENTRY_W-1:0] cell_q [NUM_BLOCKS];

    for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
        logic [ENTRY_W-1:0] above;
        logic [ENTRY_W-1:0] below;

        if (i == 0) begin : g_first
            assign above = push_data;
        end else begin : g_mid_above
            assign above = cell_q[i-1];
        end

        if (i == NUM_BLOCKS - 1) begin : g_last
            assign below = '0;
        end else begin : g_mid_below
            assign below = cell_q[i+1];
        end

        fbpa_cell #(
            .ENTRY_W   (ENTRY_W),
            .RESET_VAL (ENTRY_W'(NUM_BLOCKS - 1 - i))
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .from_above (above),
            .from_below (below),
            .value      (cell_q[i])
        );
    end

    assign top_data = cell_q[0];

endmodule
`default_nettype wire

// File: design/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator.
// Hands out and takes back equal-size blocks from a LIFO free list of block numbers held in a
// chain of NUM_BLOCKS cells that all shift together on a push or a pop. One item is taken per
// cycle while s_ready is high. The decision and stack update happen at the s_ transfer into
// stage A; the offset multiply is registered into the result stage, which drives m_valid.
// The result stage loads whenever it is empty or being read, so with m_ready low the block
// holds two items before s_ready drops. The throughput is set by the single push or pop of
// the cell chain per cycle. Reset needs no clearing pass: cell i resets to NUM_BLOCKS-1-i.
// cfg_ready is always high; write the block size only while no item is in flight.
`default_nettype none
module fixed_block_pool_allocator_top #(
    parameter int unsigned NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]       cfg_block_size_bytes,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_kind,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]       s_request_size,
    input  wire logic [fbpa_pkg::BLOCK_W-1:0]      s_freed_block,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [fbpa_pkg::STATUS_W-1:0]          m_status,
    output logic [fbpa_pkg::BLOCK_W-1:0]           m_granted_block,
    output logic [fbpa_pkg::OFFSET_W-1:0]          m_byte_offset,
    output logic [fbpa_pkg::IN_USE_W-1:0]          m_blocks_in_use
);
    import fbpa_pkg::*;

    localparam int unsigned ENTRY_W = ($clog2(NUM_BLOCKS) > BLOCK_W) ?
                                      $clog2(NUM_BLOCKS) : BLOCK_W;
    localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned PROD_W  = ENTRY_W + ASZ_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_BLOCKS);

    logic [SIZE_W-1:0]    blk_bytes_reg;
    logic [CNT_W-1:0]     free_count_reg;
    logic [CNT_W-1:0]     free_count_next;
    logic [CNT_W-1:0]     in_use_reg;
    logic [CNT_W-1:0]     in_use_next;

    logic                 a_valid_reg;
    logic [STATUS_W-1:0]  a_status_reg;
    logic [STATUS_W-1:0]  a_status_next;
    logic [ENTRY_W-1:0]   a_granted_reg;
    logic [ENTRY_W-1:0]   a_granted_next;
    logic [ASZ_W-1:0]     a_asz_reg;
    logic [CNT_W-1:0]     a_in_use_reg;

    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [BLOCK_W-1:0]   m_granted_reg;
    logic [OFFSET_W-1:0]  m_offset_reg;
    logic [IN_USE_W-1:0]  m_in_use_reg;

    logic                 accept;
    logic                 a_advance;
    logic [ASZ_W-1:0]     size_sum;
    logic [ASZ_W-1:0]     asz;
    logic [ENTRY_W-1:0]   top_data;
    logic [PROD_W-1:0]    product;
    fbpa_shift_t          shift;

    assign cfg_ready = 1'b1;
    assign a_advance = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !a_valid_reg || a_advance;
    assign accept    = s_valid && s_ready;

    assign size_sum = {1'b0, blk_bytes_reg} + ASZ_W'(ALIGN_BYTES - 1);
    assign asz      = {size_sum[ASZ_W-1:ALIGN_SHIFT], ALIGN_SHIFT'(0)};

    always_comb begin
        shift           = '0;
        a_status_next   = ST_OK;
        a_granted_next  = '0;
        free_count_next = free_count_reg;
        in_use_next     = in_use_reg;
        case (s_kind)
            KIND_ALLOC: begin
                if ({1'b0, s_request_size} > asz) begin
                    a_status_next = ST_TOO_LARGE;
                end else if (free_count_reg == '0) begin
                    a_status_next = ST_EXHAUSTED;
                end else begin
                    shift.pop       = accept;
                    a_granted_next  = top_data;
                    free_count_next = free_count_reg - 1'b1;
                    in_use_next     = in_use_reg + 1'b1;
                end
            end
            KIND_FREE: begin
                if (free_count_reg == CNT_FULL) begin
                    a_status_next = ST_LIST_FULL;
                end else begin
                    shift.push      = accept;
                    free_count_next = free_count_reg + 1'b1;
                    if (in_use_reg != '0) begin
                        in_use_next = in_use_reg - 1'b1;
                    end
                end
            end
            default: begin
                a_status_next = ST_OK;
            end
        endcase
    end

    fbpa_stack #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .ENTRY_W    (ENTRY_W)
    ) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (shift),
        .push_data (ENTRY_W'(s_freed_block)),
        .top_data  (top_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_bytes_reg  <= BLK_BYTES_RESET;
            free_count_reg <= CNT_FULL;
            in_use_reg     <= '0;
            a_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                blk_bytes_reg <= cfg_block_size_bytes;
            end
            if (accept) begin
                free_count_reg <= free_count_next;
                in_use_reg     <= in_use_next;
                a_valid_reg    <= 1'b1;
            end else if (a_advance) begin
                a_valid_reg    <= 1'b0;
            end
            if (a_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold stage A payload until it moves on
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_status_reg  <= a_status_next;
            a_granted_reg <= a_granted_next;
            a_asz_reg     <= asz;
            a_in_use_reg  <= in_use_next;
        end
    end

    assign product = a_granted_reg * a_asz_reg;

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_status_reg  <= a_status_reg;
            m_granted_reg <= a_granted_reg[BLOCK_W-1:0];
            m_offset_reg  <= product[OFFSET_W-1:0];
            m_in_use_reg  <= IN_USE_W'(a_in_use_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_block = m_granted_reg;
    assign m_byte_offset   = m_offset_reg;
    assign m_blocks_in_use = m_in_use_reg;

endmodule
`default_nettype wire

// File: design/fbpa_checker.sv
// Port-level checks of the fixed block pool allocator and their binding to the top level.
`default_nettype none
module fbpa_checker #(
    parameter int unsigned NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [fbpa_pkg::STATUS_W-1:0]     m_status,
    input wire logic [fbpa_pkg::BLOCK_W-1:0]      m_granted_block,
    input wire logic [fbpa_pkg::OFFSET_W-1:0]     m_byte_offset,
    input wire logic [fbpa_pkg::IN_USE_W-1:0]     m_blocks_in_use
);
    import fbpa_pkg::*;

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("allocator not idle after reset");

    a_refused_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_granted_block == '0 && m_byte_offset == '0)
        else $error("refused item carries a block or offset");

    a_in_use_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_blocks_in_use) <= NUM_BLOCKS)
        else $error("blocks in use exceeds pool size");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_byte_offset))
        else $error("stalled result changed");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_fbpa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_granted_block (m_granted_block),
    .m_byte_offset   (m_byte_offset),
    .m_blocks_in_use (m_blocks_in_use)
);
`default_nettype wire

// File: tb/fbpa_grant_checker.sv
// Checker for the block pool allocator: predicts each result from the accepted items and compares.
`default_nettype none
module fbpa_grant_checker #(
    parameter int unsigned NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]   cfg_block_size_bytes,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          s_kind,
    input  wire logic [fbpa_pkg::SIZE_W-1:0]   s_request_size,
    input  wire logic [fbpa_pkg::BLOCK_W-1:0]  s_freed_block,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [fbpa_pkg::STATUS_W-1:0] m_status,
    input  wire logic [fbpa_pkg::BLOCK_W-1:0]  m_granted_block,
    input  wire logic [fbpa_pkg::OFFSET_W-1:0] m_byte_offset,
    input  wire logic [fbpa_pkg::IN_USE_W-1:0] m_blocks_in_use,
    output int unsigned                        mismatches,
    output int unsigned                        outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import fbpa_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  block;
        logic [OFFSET_W-1:0] offset;
        logic [IN_USE_W-1:0] in_use;
    } grant_t;

    logic [BLOCK_W-1:0] free_list [NUM_BLOCKS];
    int unsigned        free_depth;
    int unsigned        in_use_blocks;
    logic [SIZE_W-1:0]  cfg_bytes;
    grant_t             grant_q [$];
    grant_t             want;
    grant_t             got;
    int unsigned        errs = 0;

    function automatic grant_t predict_grant(input logic kind, input logic [SIZE_W-1:0] req,
                                             input logic [BLOCK_W-1:0] freed);
        grant_t           res;
        logic [ASZ_W-1:0] asz;
        res = '0;
        res.status = ST_OK;
        asz = ({1'b0, cfg_bytes} + ASZ_W'(ALIGN_BYTES - 1)) & ~ASZ_W'(ALIGN_BYTES - 1);
        if (kind == KIND_ALLOC) begin
            if ({1'b0, req} > asz) begin
                res.status = ST_TOO_LARGE;
            end else if (free_depth == 0) begin
                res.status = ST_EXHAUSTED;
            end else begin
                free_depth--;
                res.block = free_list[free_depth];
                in_use_blocks++;
                res.offset = OFFSET_W'(32'(res.block) * 32'(asz));
            end
        end else begin
            if (free_depth >= NUM_BLOCKS) begin
                res.status = ST_LIST_FULL;
            end else begin
                free_list[free_depth] = freed;
                free_depth++;
                if (in_use_blocks > 0) in_use_blocks--;
            end
        end
        res.in_use = IN_USE_W'(in_use_blocks);
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NUM_BLOCKS; j++) free_list[j] = BLOCK_W'(j);
            free_depth    = NUM_BLOCKS;
            in_use_blocks = 0;
            cfg_bytes     = BLK_BYTES_RESET;
            grant_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) cfg_bytes = cfg_block_size_bytes;
            if (m_valid && m_ready) begin
                got = '{m_status, m_granted_block, m_byte_offset, m_blocks_in_use};
                if (grant_q.size() == 0) begin
                    if (errs < 10)
                        $display({"[%0t] unexpected result: status %0d block %0d ",
                                  "offset %0d in_use %0d"},
                                 $realtime, got.status, got.block, got.offset, got.in_use);
                    errs++;
                end else begin
                    want = grant_q.pop_front();
                    if (got !== want) begin
                        if (errs < 10)
                            $display({"[%0t] result differs: status %0d/%0d block %0d/%0d ",
                                      "offset %0d/%0d in_use %0d/%0d (expected/actual)"},
                                     $realtime, want.status, got.status, want.block, got.block,
                                     want.offset, got.offset, want.in_use, got.in_use);
                        errs++;
                    end
                end
            end
            if (s_valid && s_ready)
                grant_q.push_back(predict_grant(s_kind, s_request_size, s_freed_block));
        end
        mismatches  <= errs;
        outstanding <= grant_q.size();
    end

endmodule
`default_nettype wire

// File: tb/fixed_block_pool_allocator_top_tb.sv
// Testbench top for the block pool allocator: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none
module fixed_block_pool_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fbpa_pkg::*;

    localparam int unsigned CLK_PERIOD  = 4;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned NUM_PHASES  = 6;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_block_size_bytes = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_kind = KIND_ALLOC;
    logic [SIZE_W-1:0]   s_request_size = '0;
    logic [BLOCK_W-1:0]  s_freed_block = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [BLOCK_W-1:0]  m_granted_block;
    logic [OFFSET_W-1:0] m_byte_offset;
    logic [IN_USE_W-1:0] m_blocks_in_use;
    int unsigned         mismatches;
    int unsigned         outstanding;

    logic                calm = 1'b0;
    logic                hold_req = 1'b0;
    logic                hold_taken = 1'b0;
    int unsigned         hold_left = 0;
    logic [SIZE_W-1:0]   cur_size = BLK_BYTES_RESET;

    int unsigned         phase_len   [NUM_PHASES] = '{300, 280, 250, 250, 250, 220};
    int unsigned         phase_alloc [NUM_PHASES] = '{98, 3, 92, 50, 8, 85};
    logic [SIZE_W-1:0]   phase_size  [NUM_PHASES] = '{16'd65535, 16'd1, 16'd0, 16'd0, 16'd8, 16'd0};

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    fixed_block_pool_allocator_top i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_block_size_bytes(cfg_block_size_bytes),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_request_size      (s_request_size),
        .s_freed_block       (s_freed_block),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_granted_block     (m_granted_block),
        .m_byte_offset       (m_byte_offset),
        .m_blocks_in_use     (m_blocks_in_use)
    );

    fbpa_grant_checker i_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_block_size_bytes(cfg_block_size_bytes),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_kind              (s_kind),
        .s_request_size      (s_request_size),
        .s_freed_block       (s_freed_block),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_granted_block     (m_granted_block),
        .m_byte_offset       (m_byte_offset),
        .m_blocks_in_use     (m_blocks_in_use),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    // hold off once for a long stretch so the pipeline fills and stalls the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic send_item(input logic kind, input logic [SIZE_W-1:0] req,
                             input logic [BLOCK_W-1:0] freed);
        while (!calm && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_request_size <= req;
        s_freed_block  <= freed;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_block_size(input logic [SIZE_W-1:0] value);
        cfg_valid            <= 1'b1;
        cfg_block_size_bytes <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_size = value;
    endtask

    function automatic logic [SIZE_W-1:0] pick_request(input logic [SIZE_W-1:0] size);
        int unsigned asz;
        int unsigned cap;
        int unsigned sel;
        asz = (int'(size) + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
        cap = (asz > 65535) ? 65535 : asz;
        sel = $urandom_range(0, 99);
        if (sel < 40) return SIZE_W'($urandom_range(0, cap));
        else if (sel < 55) return SIZE_W'(cap);
        else if (sel < 65) return (asz < 65535) ? SIZE_W'(asz + 1) : SIZE_W'($urandom);
        else if (sel < 80) return '0;
        else return SIZE_W'($urandom);
    endfunction

    initial begin
        logic        kind;
        logic [15:0] size;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // free into a full list, aligned-size edges, double free handed out twice
        send_item(KIND_FREE,  16'hFFFF, 8'd0);
        send_item(KIND_FREE,  16'h0000, 8'd255);
        send_item(KIND_ALLOC, 16'd0,     8'hFF);
        send_item(KIND_ALLOC, 16'd64,    8'h00);
        send_item(KIND_ALLOC, 16'd65,    8'h00);
        send_item(KIND_ALLOC, 16'hFFFF,  8'h00);
        send_item(KIND_FREE,  16'd0,     8'd255);
        send_item(KIND_ALLOC, 16'd1,     8'd0);
        send_item(KIND_FREE,  16'd0,     8'd0);
        send_item(KIND_FREE,  16'd0,     8'd0);
        send_item(KIND_FREE,  16'd0,     8'd7);
        send_item(KIND_ALLOC, 16'd57,    8'd0);
        send_item(KIND_ALLOC, 16'd63,    8'd0);
        send_item(KIND_FREE,  16'd0,     8'hAA);
        send_item(KIND_FREE,  16'd0,     8'h55);
        send_item(KIND_ALLOC, 16'd8,     8'd0);
        send_item(KIND_ALLOC, 16'd64,    8'd0);
        send_item(KIND_ALLOC, 16'd0,     8'd0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            size = (p == 3 || p == 5) ? 16'($urandom_range(1, 65535)) : phase_size[p];
            write_block_size(size);
            calm <= (p == 3);
            if (p == 2) hold_req <= 1'b1;
            for (int i = 0; i < phase_len[p]; i++) begin
                kind = ($urandom_range(0, 99) < phase_alloc[p]) ? KIND_ALLOC : KIND_FREE;
                send_item(kind, pick_request(cur_size), BLOCK_W'($urandom));
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("fixed_block_pool_allocator_top: match");
        end else begin
            $display("fixed_block_pool_allocator_top: mismatch");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("fixed_block_pool_allocator_top: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
